// ----- design/vptw_pkg.sv -----
`timescale 1ns / 1ps
package vptw_pkg;

    localparam int VPTW_FRAC_BITS = 16;

    typedef logic signed [31:0] t_word;
    typedef logic signed [67:0] t_wide;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_MODEL = 2'd1,
        KIND_PROJ  = 2'd2
    } t_kind;

    localparam logic [7:0] REG_VP_X = 8'd0;
    localparam logic [7:0] REG_VP_Y = 8'd1;
    localparam logic [7:0] REG_VP_W = 8'd2;
    localparam logic [7:0] REG_VP_H = 8'd3;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    function automatic t_word sat32(input t_wide v);
        if (v > 68'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < 68'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// ----- design/vertex_project_to_window.sv -----
`timescale 1ns / 1ps
// Projects object-space points through a stored model matrix and projection
// matrix, divides by clip w and maps the result into the viewport, all in
// signed fixed point with FRAC_BITS fractional bits (Q16.16 by default). One
// point word is taken every cycle while the consumer takes results; a point
// passes through the two matrix units, the restoring divider that settles
// one quotient bit per stage over 32 + FRAC_BITS stages, and the viewport
// mapping. A matrix-write word is held off until every point in flight has
// left the pipeline, so a write can wait out the whole pipeline before it
// is accepted. Configuration writes are always accepted.
module vertex_project_to_window #(
    parameter int FRAC_BITS = vptw_pkg::VPTW_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_kind,
    input  logic [3:0]      i_coef_index,
    input  vptw_pkg::t_word i_coef_value,
    input  vptw_pkg::t_word i_obj_x,
    input  vptw_pkg::t_word i_obj_y,
    input  vptw_pkg::t_word i_obj_z,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output vptw_pkg::t_word o_win_x,
    output vptw_pkg::t_word o_win_y,
    output vptw_pkg::t_word o_win_z,
    output logic            o_ok,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);
    import vptw_pkg::*;

    localparam t_word             ID_ONE = t_word'(1 << FRAC_BITS);
    localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;

    t_word              r_model [16];
    t_word              r_proj  [16];
    logic signed [15:0] r_vp_x;
    logic signed [15:0] r_vp_y;
    logic [13:0]        r_vp_w;
    logic [13:0]        r_vp_h;

    logic  en;
    logic  busy;
    logic  in_acc;
    logic  m_valid, m_busy, p_valid, p_busy, d_valid, d_busy, d_dz;
    t_word obj [3];
    t_word eye [4];
    t_word eye3 [3];
    t_word clip [4];
    t_word clip3 [3];
    t_word quo [3];

    logic               r_m_v;
    logic               r_m_dz;
    logic signed [47:0] r_px;
    logic signed [47:0] r_py;
    t_word              r_z;
    logic signed [32:0] n_ax, n_ay, n_az;

    logic  r_out_v;
    t_word r_wx, r_wy, r_wz;
    logic  r_ok;

    // The whole pipeline moves together; it stops only when a finished
    // result is waiting and the consumer is not taking it.
    assign en         = !r_out_v || i_out_ready;
    assign busy       = m_busy | p_busy | d_busy | r_m_v;
    assign o_in_ready = en && ((i_kind == KIND_POINT) || !busy);
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_model[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ID_ONE : '0;
                r_proj[i]  <= (i == 0 || i == 5 || i == 10 || i == 15) ? ID_ONE : '0;
            end
            r_vp_x <= '0;
            r_vp_y <= '0;
            r_vp_w <= 14'd640;
            r_vp_h <= 14'd480;
        end else begin
            if (in_acc && i_kind == KIND_MODEL) begin
                r_model[i_coef_index] <= i_coef_value;
            end
            if (in_acc && i_kind == KIND_PROJ) begin
                r_proj[i_coef_index] <= i_coef_value;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_VP_X: r_vp_x <= i_cfg_data;
                    REG_VP_Y: r_vp_y <= i_cfg_data;
                    REG_VP_W: r_vp_w <= i_cfg_data[13:0];
                    REG_VP_H: r_vp_h <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
        end
    end

    assign obj   = '{i_obj_x, i_obj_y, i_obj_z};
    assign eye3  = '{eye[0], eye[1], eye[2]};
    assign clip3 = '{clip[0], clip[1], clip[2]};

    vptw_xform #(.FRAC_BITS(FRAC_BITS)) u_model (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (in_acc && (i_kind == KIND_POINT)),
        .i_vec   (obj),
        .i_mat   (r_model),
        .o_valid (m_valid),
        .o_busy  (m_busy),
        .o_vec   (eye)
    );

    vptw_xform #(.FRAC_BITS(FRAC_BITS)) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m_valid),
        .i_vec   (eye3),
        .i_mat   (r_proj),
        .o_valid (p_valid),
        .o_busy  (p_busy),
        .o_vec   (clip)
    );

    vptw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_num   (clip3),
        .i_den   (clip[3]),
        .o_valid (d_valid),
        .o_busy  (d_busy),
        .o_dz    (d_dz),
        .o_quo   (quo)
    );

    assign n_ax = 33'(quo[0]) + ONE33;
    assign n_ay = 33'(quo[1]) + ONE33;
    assign n_az = 33'(quo[2]) + ONE33;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_m_v   <= d_valid;
            r_out_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_dz <= d_dz;
            r_px   <= 48'(n_ax) * 48'($signed({1'b0, r_vp_w}));
            r_py   <= 48'(n_ay) * 48'($signed({1'b0, r_vp_h}));
            r_z    <= sat32(68'(n_az >>> 1));
            if (r_m_dz) begin
                r_wx <= '0;
                r_wy <= '0;
                r_wz <= '0;
                r_ok <= 1'b0;
            end else begin
                r_wx <= sat32((68'(r_vp_x) <<< FRAC_BITS) + 68'(r_px >>> 1));
                r_wy <= sat32((68'(r_vp_y) <<< FRAC_BITS) + 68'(r_py >>> 1));
                r_wz <= r_z;
                r_ok <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_win_x     = r_wx;
    assign o_win_y     = r_wy;
    assign o_win_z     = r_wz;
    assign o_ok        = r_ok;

endmodule

// ----- design/vptw_xform.sv -----
`timescale 1ns / 1ps
module vptw_xform #(
    parameter int FRAC_BITS = vptw_pkg::VPTW_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  vptw_pkg::t_word i_vec [3],
    input  vptw_pkg::t_word i_mat [16],
    output logic            o_valid,
    output logic            o_busy,
    output vptw_pkg::t_word o_vec [4]
);
    import vptw_pkg::*;

    logic signed [63:0] r_prod [4][3];
    t_word              r_bias [4];
    t_word              r_out  [4];
    t_word              n_out  [4];
    logic               r_v1;
    logic               r_v2;

    // The w input is always one, so the last column enters as it is.
    always_comb begin
        t_wide acc;
        for (int r = 0; r < 4; r++) begin
            acc = 68'(r_bias[r]);
            for (int c = 0; c < 3; c++) begin
                acc = acc + 68'(r_prod[r][c] >>> FRAC_BITS);
            end
            n_out[r] = sat32(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_bias[r] <= i_mat[12 + r];
                r_out[r]  <= n_out[r];
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= 64'(i_mat[c * 4 + r]) * 64'(i_vec[c]);
                end
            end
        end
    end

    assign o_valid = r_v2;
    assign o_busy  = r_v1 | r_v2;
    assign o_vec   = r_out;

endmodule

// ----- design/vptw_div.sv -----
`timescale 1ns / 1ps
module vptw_div #(
    parameter int FRAC_BITS = vptw_pkg::VPTW_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  vptw_pkg::t_word i_num [3],
    input  vptw_pkg::t_word i_den,
    output logic            o_valid,
    output logic            o_busy,
    output logic            o_dz,
    output vptw_pkg::t_word o_quo [3]
);
    import vptw_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    // Stage 0 holds magnitudes; each later stage settles one quotient bit,
    // which shifts into the low end of the dividend word.
    logic [DW-1:0] r_dvd [DW+1][3];
    logic [31:0]   r_rem [DW+1][3];
    logic          r_neg [DW+1][3];
    logic [31:0]   r_d   [DW+1];
    logic          r_dz  [DW+1];
    logic          r_v   [DW+1];
    logic [31:0]   n_rem [DW][3];
    logic          n_ge  [DW][3];
    logic [31:0]   n_abs [3];
    logic [31:0]   n_dabs;
    t_word         n_oq  [3];
    t_word         r_oq  [3];
    logic          r_ov;
    logic          r_odz;

    always_comb begin
        logic [32:0] trial;
        for (int l = 0; l < 3; l++) begin
            n_abs[l] = i_num[l][31] ? 32'(-i_num[l]) : i_num[l];
        end
        n_dabs = i_den[31] ? 32'(-i_den) : i_den;
        for (int s = 1; s <= DW; s++) begin
            for (int l = 0; l < 3; l++) begin
                trial = {r_rem[s-1][l], r_dvd[s-1][l][DW-1]};
                n_ge[s-1][l]  = trial >= {1'b0, r_d[s-1]};
                n_rem[s-1][l] = n_ge[s-1][l] ? 32'(trial - {1'b0, r_d[s-1]}) : trial[31:0];
            end
        end
    end

    always_comb begin
        logic [DW-1:0] mag;
        for (int l = 0; l < 3; l++) begin
            mag = r_dvd[DW][l];
            if (!r_neg[DW][l]) begin
                n_oq[l] = (|mag[DW-1:31]) ? WORD_MAX : mag[31:0];
            end else if ((|mag[DW-1:32]) || (mag[31] && (|mag[30:0]))) begin
                n_oq[l] = WORD_MIN;
            end else begin
                n_oq[l] = 32'(-mag[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DW; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= DW; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]  <= n_dabs;
            r_dz[0] <= (i_den == '0);
            for (int l = 0; l < 3; l++) begin
                r_dvd[0][l] <= {n_abs[l], {FRAC_BITS{1'b0}}};
                r_rem[0][l] <= '0;
                r_neg[0][l] <= i_num[l][31] ^ i_den[31];
            end
            for (int s = 1; s <= DW; s++) begin
                r_d[s]  <= r_d[s-1];
                r_dz[s] <= r_dz[s-1];
                for (int l = 0; l < 3; l++) begin
                    r_dvd[s][l] <= {r_dvd[s-1][l][DW-2:0], n_ge[s-1][l]};
                    r_rem[s][l] <= n_rem[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                end
            end
            r_oq  <= n_oq;
            r_odz <= r_dz[DW];
        end
    end

    always_comb begin
        o_busy = r_ov;
        for (int s = 0; s <= DW; s++) begin
            o_busy = o_busy | r_v[s];
        end
    end

    assign o_valid = r_ov;
    assign o_dz    = r_odz;
    assign o_quo   = r_oq;

endmodule
